@@ hw/rtl/snapshot_pair_interpolator_defines.svh @@
// assertion macros for the snapshot pair interpolator
// included by the queue and back-end modules, no other dependencies
`ifndef SNAPSHOT_PAIR_INTERPOLATOR_DEFINES_SVH
`define SNAPSHOT_PAIR_INTERPOLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define SNPI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SNPI_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define SNPI_ASSERT(lbl, clk, rstn, prop, msg)
`define SNPI_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

@@ hw/rtl/snpi_pkg.sv @@
// shared types and constants of the snapshot pair interpolator
// no dependencies; imported by every module of the block
package snpi_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int SAT_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  // port field widths
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int BOX_W   = 31;
  localparam int SCALE_W = 32;
  localparam int IDX_W   = 3;
  localparam int IN_DATA_W  = 4 * VAL_W;
  localparam int OUT_DATA_W = VAL_W;

  // internal datapath widths
  localparam int X2W_W   = VAL_W + 2;       // wrapped second value
  localparam int DIFF_W  = VAL_W + 3;       // x2w - x1
  localparam int PROD1_W = 2 * VAL_W + 1;   // v1 * vel_scale_first
  localparam int D1_W    = PROD1_W - 24;    // displacement in Q16.16
  localparam int E_W     = D1_W + 3;
  localparam int P_W     = E_W + FRAC_W + 1;
  localparam int PH_W    = P_W - 16;
  localparam int S_W     = PH_W + 1;
  localparam int SF_W    = S_W + FRAC_W + 1;
  localparam int LP_W    = DIFF_W + FRAC_W + 1;
  localparam int ACC_W   = 64;
  localparam int RES_W   = ACC_W - 16;
  localparam int PLF_W   = 2 * FRAC_W;
  localparam int BB_W    = PLF_W + 1 - 16;

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((longint'(1) <<< (SAT_BITS - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam int BACK_STAGES = 5;

  typedef enum logic [IDX_W-1:0] {
    REG_FRACTION         = 3'd0,
    REG_BOX_SIZE         = 3'd1,
    REG_PERIODIC_WRAP    = 3'd2,
    REG_INTERP_MODE      = 3'd3,
    REG_VEL_SCALE_FIRST  = 3'd4,
    REG_VEL_SCALE_SECOND = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_POSITION  = 1'b0,
    CMD_ATTRIBUTE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [FRAC_W-1:0]  fraction;
    logic [BOX_W-1:0]   box_size;
    logic               periodic_wrap;
    logic               interp_mode;
    logic [SCALE_W-1:0] vel_scale_first;
  } cfg_t;

  typedef struct packed {
    logic                     quad;
    logic                     wrapped;
    logic signed [VAL_W-1:0]  x1;
    logic signed [X2W_W-1:0]  x2w;
    logic signed [VAL_W-1:0]  v1;
  } item_t;

endpackage

@@ hw/rtl/snpi_front.sv @@
// front end: takes requests, applies the periodic wrap and picks the mode
// depends on snpi_pkg; feeds snpi_queue
module snpi_front import snpi_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  cfg_t                 cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output item_t                q_item
);

  logic signed [VAL_W-1:0]  x1;
  logic signed [VAL_W-1:0]  x2;
  logic signed [VAL_W:0]    diff;
  logic        [VAL_W:0]    adiff;
  logic                     far;
  logic                     pos;
  logic                     do_wrap;
  logic signed [X2W_W-1:0]  x2e;
  logic signed [X2W_W-1:0]  boxe;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    x1   = $signed(in_tdata[VAL_W-1:0]);
    x2   = $signed(in_tdata[2*VAL_W-1:VAL_W]);
    pos  = (cmd_t'(in_tuser) == CMD_POSITION);
    diff = (VAL_W+1)'(x2) - (VAL_W+1)'(x1);
    adiff = diff[VAL_W] ? $unsigned(-diff) : $unsigned(diff);
    // more than half a box away: 2*|d| > box
    far  = {adiff, 1'b0} > (VAL_W+2)'(cfg.box_size);
    do_wrap = pos && cfg.periodic_wrap && far;
    x2e  = X2W_W'(x2);
    boxe = $signed(X2W_W'(cfg.box_size));
    q_item.x1      = x1;
    q_item.v1      = $signed(in_tdata[3*VAL_W-1:2*VAL_W]);
    q_item.wrapped = do_wrap;
    q_item.quad    = pos && cfg.interp_mode;
    if (!do_wrap) begin
      q_item.x2w = x2e;
    end else if (!diff[VAL_W] && (diff != '0)) begin
      q_item.x2w = x2e - boxe;
    end else begin
      q_item.x2w = x2e + boxe;
    end
  end

endmodule

@@ hw/rtl/snpi_queue.sv @@
// short request queue between the front end and the arithmetic back end
// depends on snpi_pkg and the assertion macro header
`include "snapshot_pair_interpolator_defines.svh"
module snpi_queue import snpi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t rdata
);

  item_t                ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rdata    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  `SNPI_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && full, "push into full queue")
  `SNPI_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && !nonempty, "pop from empty queue")
  `SNPI_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= Q_CNT_W'(Q_DEPTH), "queue count out of range")
  `SNPI_ASSERT(a_ptr_gap, clk, rst_n, (wr_ptr_r - rd_ptr_r) == Q_PTR_W'(cnt_r), "pointer gap mismatch")

endmodule

@@ hw/rtl/snpi_back.sv @@
// back end: five-stage interpolation pipeline plus the output register
// depends on snpi_pkg and the assertion macro header; fed by snpi_queue
`include "snapshot_pair_interpolator_defines.svh"
module snpi_back import snpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam logic signed [PROD1_W-1:0] D1_RND  = PROD1_W'(1) <<< 23;
  localparam logic signed [ACC_W-1:0]   LIN_RND = ACC_W'(32768);
  localparam logic        [PLF_W:0]     QD_RND  = (PLF_W+1)'(1) << 31;

  logic                    adv;
  logic [BACK_STAGES-1:0]  vld_r;
  logic                    out_valid_r;
  logic signed [FRAC_W:0]  fs;

  // stage 1
  logic                      s1_quad_r, s1_wrap_r;
  logic signed [VAL_W-1:0]   s1_x1_r;
  logic signed [DIFF_W-1:0]  s1_diff_r;
  logic signed [PROD1_W-1:0] s1_m1_r;
  // stage 2
  logic                      s2_quad_r, s2_wrap_r;
  logic signed [VAL_W-1:0]   s2_x1_r;
  logic signed [DIFF_W-1:0]  s2_diff_r;
  logic signed [D1_W-1:0]    s2_d1_r;
  logic signed [LP_W-1:0]    s2_lp_r;
  // stage 3
  logic                      s3_quad_r, s3_wrap_r;
  logic signed [VAL_W-1:0]   s3_x1_r;
  logic signed [D1_W-1:0]    s3_d1_r;
  logic signed [P_W-1:0]     s3_p_r;
  logic signed [RES_W-1:0]   s3_lin_r;
  // stage 4
  logic                      s4_quad_r, s4_wrap_r;
  logic signed [VAL_W-1:0]   s4_x1_r;
  logic signed [S_W-1:0]     s4_s_r;
  logic        [PLF_W-1:0]   s4_plf_r;
  logic signed [RES_W-1:0]   s4_lin_r;
  // stage 5
  logic                      s5_quad_r, s5_wrap_r;
  logic signed [VAL_W-1:0]   s5_x1_r;
  logic signed [SF_W-1:0]    s5_sf_r;
  logic        [BB_W-1:0]    s5_bb_r;
  logic signed [RES_W-1:0]   s5_lin_r;

  logic signed [PROD1_W-1:0] d1_sum;
  logic signed [E_W-1:0]     e_c;
  logic signed [ACC_W-1:0]   lin_sum;
  logic signed [PH_W-1:0]    ph_c;
  logic        [PLF_W:0]     qd_sum;
  logic signed [ACC_W-1:0]   acc;
  logic signed [RES_W-1:0]   res;
  logic signed [RES_W-1:0]   sat;

  // whole pipe moves when the output register is free or being drained
  assign adv        = !out_valid_r || out_tready;
  assign q_pop      = adv && q_valid;
  assign out_tvalid = out_valid_r;
  assign fs         = $signed({1'b0, cfg.fraction});

  always_comb begin
    d1_sum  = s1_m1_r + D1_RND;
    e_c     = E_W'(s2_diff_r) - E_W'(s2_d1_r);
    lin_sum = (ACC_W'(s2_x1_r) <<< 16) + ACC_W'(s2_lp_r) + LIN_RND;
    ph_c    = s3_p_r[P_W-1:16];
    qd_sum  = (PLF_W+1)'(s4_plf_r) + QD_RND;
    acc     = (ACC_W'(s5_x1_r) <<< 16) + ACC_W'(s5_sf_r) + $signed(ACC_W'(s5_bb_r));
    res     = s5_quad_r ? acc[ACC_W-1:16] : s5_lin_r;
    if (res > SAT_HI) begin
      sat = SAT_HI;
    end else if (res < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[BACK_STAGES-2:0], q_valid};
      out_valid_r <= vld_r[BACK_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: velocity scaling and the position difference
      s1_quad_r <= q_item.quad;
      s1_wrap_r <= q_item.wrapped;
      s1_x1_r   <= q_item.x1;
      s1_diff_r <= DIFF_W'(q_item.x2w) - DIFF_W'(q_item.x1);
      s1_m1_r   <= PROD1_W'(q_item.v1) * PROD1_W'($signed({1'b0, cfg.vel_scale_first}));
      // stage 2: round displacement, linear product
      s2_quad_r <= s1_quad_r;
      s2_wrap_r <= s1_wrap_r;
      s2_x1_r   <= s1_x1_r;
      s2_diff_r <= s1_diff_r;
      s2_d1_r   <= d1_sum[PROD1_W-1:24];
      s2_lp_r   <= LP_W'(s1_diff_r) * LP_W'(fs);
      // stage 3: curvature term e*t, linear result done
      s3_quad_r <= s2_quad_r;
      s3_wrap_r <= s2_wrap_r;
      s3_x1_r   <= s2_x1_r;
      s3_d1_r   <= s2_d1_r;
      s3_p_r    <= P_W'(e_c) * P_W'(fs);
      s3_lin_r  <= lin_sum[ACC_W-1:16];
      // stage 4: split e*t into integer and fractional parts
      s4_quad_r <= s3_quad_r;
      s4_wrap_r <= s3_wrap_r;
      s4_x1_r   <= s3_x1_r;
      s4_s_r    <= S_W'(s3_d1_r) + S_W'(ph_c);
      s4_plf_r  <= PLF_W'(s3_p_r[15:0]) * PLF_W'(cfg.fraction);
      s4_lin_r  <= s3_lin_r;
      // stage 5: (d1 + floor(e*t)) * t and rounded fractional carry
      s5_quad_r <= s4_quad_r;
      s5_wrap_r <= s4_wrap_r;
      s5_x1_r   <= s4_x1_r;
      s5_sf_r   <= SF_W'(s4_s_r) * SF_W'(fs);
      s5_bb_r   <= qd_sum[PLF_W:16];
      s5_lin_r  <= s4_lin_r;
      // output register
      out_tdata <= sat[OUT_DATA_W-1:0];
      out_tuser <= s5_wrap_r;
    end
  end

  `SNPI_ASSERT(a_hold_on_stall, clk, rst_n, !adv |=> $stable(vld_r), "pipe moved while stalled")
  `SNPI_ASSERT(a_pop_enters, clk, rst_n, q_pop |=> vld_r[0], "popped request lost")

endmodule

@@ hw/rtl/snapshot_pair_interpolator.sv @@
// top level of the snapshot pair interpolator: configuration registers and wiring
// depends on snpi_pkg, snpi_front, snpi_queue and snpi_back
//
// Interpolates one quantity of a matched particle between two snapshots at
// t = fraction / 65536. A position request (tuser 0) may have its second value
// moved by one box toward the first when the two lie more than half a box apart,
// then is interpolated linearly or, with interp_mode set, quadratically from the
// first position, the scaled first velocity and the second position. An attribute
// request (tuser 1) is always linear and never wrapped. Each request gives exactly
// one result, rounded and saturated to signed Q16.16. One request is taken every
// cycle while the queue is not full; each request passes through the queue, the
// five multiplier stages of the back end and the output register. A four-entry
// queue sits between the wrap front end and the arithmetic back end, so input
// keeps flowing until the queue fills while the output side stalls. second_velocity and
// vel_scale_second cancel out of the quadratic form and are not used. Write the
// configuration only when the block is idle.
module snapshot_pair_interpolator import snpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [SCALE_W-1:0]    cfg_wdata,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_value[31:0], second_value[63:32], first_velocity[95:64],
  // second_velocity[127:96]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic                  in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // value[31:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // wrapped[0]
  output logic                  out_tuser
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_nonempty;
  item_t q_wdata;
  item_t q_rdata;

  // register file; second velocity scale is accepted and dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRACTION:         cfg_nxt.fraction        = cfg_wdata[FRAC_W-1:0];
        REG_BOX_SIZE:         cfg_nxt.box_size        = cfg_wdata[BOX_W-1:0];
        REG_PERIODIC_WRAP:    cfg_nxt.periodic_wrap   = cfg_wdata[0];
        REG_INTERP_MODE:      cfg_nxt.interp_mode     = cfg_wdata[0];
        REG_VEL_SCALE_FIRST:  cfg_nxt.vel_scale_first = cfg_wdata;
        REG_VEL_SCALE_SECOND: cfg_nxt = cfg_r;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fraction        <= '0;
      cfg_r.box_size        <= '0;
      cfg_r.periodic_wrap   <= 1'b1;
      cfg_r.interp_mode     <= 1'b0;
      cfg_r.vel_scale_first <= SCALE_W'(32'h0100_0000);  // 1.0 in Q8.24
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // wrap decision and mode select at the input
  snpi_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wdata)
  );

  // decouples the front end from back-end stalls
  snpi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  // multiply pipeline and output register
  snpi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_nonempty),
    .q_item     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ tb/snapshot_pair_interpolator_tb.sv @@
// self-checking testbench for snapshot_pair_interpolator: random stream stimulus,
// an in-bench fixed-point predictor and an in-order result scoreboard
// depends on snpi_pkg and the snapshot_pair_interpolator rtl only

// expected-result store and fixed-point predictor
class interp_scoreboard;
  typedef struct {
    logic [31:0] value;
    logic        wrapped;
  } result_t;

  result_t expected_results[$];

  // shadow copy of the configuration registers
  longint frac_q16;
  longint box_len;
  bit     wrap_en;
  bit     quad_en;
  longint vel_first_q24;
  longint vel_second_q24;

  int errors;

  function new();
    frac_q16       = 0;
    box_len        = 0;
    wrap_en        = 1'b1;
    quad_en        = 1'b0;
    vel_first_q24  = 64'd16777216;
    vel_second_q24 = 64'd16777216;
    errors         = 0;
  endfunction

  function void set_reg(logic [snpi_pkg::IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      snpi_pkg::REG_FRACTION:         frac_q16       = longint'(data[15:0]);
      snpi_pkg::REG_BOX_SIZE:         box_len        = longint'(data[30:0]);
      snpi_pkg::REG_PERIODIC_WRAP:    wrap_en        = data[0];
      snpi_pkg::REG_INTERP_MODE:      quad_en        = data[0];
      snpi_pkg::REG_VEL_SCALE_FIRST:  vel_first_q24  = longint'(data);
      // cancels out of the quadratic form, kept only as register state
      snpi_pkg::REG_VEL_SCALE_SECOND: vel_second_q24 = longint'(data);
      default: ;
    endcase
  endfunction

  function result_t interpolate(snpi_pkg::cmd_t cmd, logic signed [31:0] x1v,
                                logic signed [31:0] x2v, logic signed [31:0] v1v);
    longint  x1, x2, v1, f, d, ad, d1, e, p, ph, pl, a, b, r, sat_max, sat_min;
    result_t res;
    x1 = x1v;
    x2 = x2v;
    v1 = v1v;
    f  = frac_q16;
    res.wrapped = 1'b0;
    // periodic wrap of position axes, second value kept at full width
    if (cmd == snpi_pkg::CMD_POSITION && wrap_en) begin
      d  = x2 - x1;
      ad = (d < 0) ? -d : d;
      if (2 * ad > box_len) begin
        if (x2 > x1) x2 = x2 - box_len;
        else x2 = x2 + box_len;
        res.wrapped = 1'b1;
      end
    end
    if (cmd == snpi_pkg::CMD_POSITION && quad_en) begin
      // displacement from first velocity, round half up to q16.16
      d1 = (v1 * vel_first_q24 + (longint'(1) <<< 23)) >>> 24;
      e  = x2 - x1 - d1;
      p  = e * f;
      ph = p >>> 16;
      pl = p - ph * 65536;
      a  = x1 * 65536 + d1 * f + ph * f;
      b  = pl * f + (longint'(1) <<< 31);
      r  = (a + (b >>> 16)) >>> 16;
    end else begin
      r = ((65536 - f) * x1 + f * x2 + 32768) >>> 16;
    end
    sat_max = (longint'(1) <<< (snpi_pkg::SAT_BITS - 1)) - 1;
    sat_min = -sat_max - 1;
    if (r > sat_max) r = sat_max;
    if (r < sat_min) r = sat_min;
    res.value = r[31:0];
    return res;
  endfunction

  function void note_request(snpi_pkg::cmd_t cmd, logic [31:0] x1, logic [31:0] x2,
                             logic [31:0] v1);
    expected_results.insert(expected_results.size(), interpolate(cmd, x1, x2, v1));
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  task flag_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task check_result(logic [31:0] value, logic wrapped);
    result_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("result %h/%b with no request pending", value, wrapped));
    end else begin
      want = expected_results.pop_front();
      if (value !== want.value)
        flag_mismatch($sformatf("value got %h want %h", value, want.value));
      if (wrapped !== want.wrapped)
        flag_mismatch($sformatf("wrapped got %b want %b", wrapped, want.wrapped));
    end
  endtask
endclass

module snapshot_pair_interpolator_tb;
  import snpi_pkg::*;

  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  // register indexes that decode to nothing
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int RAND_PHASES    = 8;
  localparam int RAND_PER_PHASE = 238;
  // cycles with no handshake at all before giving up
  localparam int QUIET_LIMIT    = 2000;
  // generous tail: the back-end pipe plus the four-entry queue
  localparam int TAIL_CYCLES    = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [SCALE_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // first_value, second_value, first_velocity, second_velocity from bit 0 up
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // cmd
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // value
  logic [OUT_DATA_W-1:0] out_tdata;
  // wrapped
  logic                  out_tuser;

  // when set, neither side idles
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  interp_scoreboard sb;

  snapshot_pair_interpolator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, result checking and the watchdog
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= 31);
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one register write; the caller drops the write enable after a batch
  task write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // full register set, optionally followed by writes to unused indexes
  task program_regs(logic [15:0] fr, logic [30:0] box, bit wrap, bit quad,
                    logic [31:0] vs1, logic [31:0] vs2, bit spare);
    write_reg(REG_FRACTION, 32'(fr));
    write_reg(REG_BOX_SIZE, 32'(box));
    write_reg(REG_PERIODIC_WRAP, 32'(wrap));
    write_reg(REG_INTERP_MODE, 32'(quad));
    write_reg(REG_VEL_SCALE_FIRST, vs1);
    write_reg(REG_VEL_SCALE_SECOND, vs2);
    if (spare) begin
      // must not alias onto any real register
      write_reg(REG_SPARE_A, 32'h0);
      write_reg(REG_SPARE_B, 32'h0);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // random gaps ahead of the request, then hold it until taken
  task send_request(cmd_t cmd, logic [31:0] x1, logic [31:0] x2, logic [31:0] v1,
                    logic [31:0] v2);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 31) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v2, v1, x2, x1};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, x1, x2, v1);
  endtask

  // sender goes quiet until every pending result is back
  task wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task random_setting();
    logic [15:0] fr;
    logic [30:0] box;
    logic [31:0] vs1;
    case ($urandom_range(0, 4))
      0:       fr = 16'h0000;
      1:       fr = 16'hFFFF;
      default: fr = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       box = 31'h0;
      1:       box = 31'h7FFF_FFFF;
      2:       box = 31'($urandom());
      default: box = 31'($urandom_range(1 << 12, 1 << 28));
    endcase
    case ($urandom_range(0, 5))
      0:       vs1 = 32'h0;
      1:       vs1 = 32'hFFFF_FFFF;
      2:       vs1 = 32'h0100_0000;
      3:       vs1 = $urandom();
      default: vs1 = $urandom_range(32'h0080_0000, 32'h0200_0000);
    endcase
    program_regs(fr, box, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), vs1,
                 $urandom(), 1'b0);
  endtask

  // mostly positions placed around the box and its half-box boundary
  task send_random_request();
    logic [31:0] x1, x2, v1, r;
    longint      b, base, delta;
    int          kind;
    cmd_t        cmd;
    b = sb.box_len;
    kind = $urandom_range(0, 99);
    r = $urandom();
    case ($urandom_range(0, 4))
      0, 1:    v1 = $urandom();
      2:       v1 = 32'h0;
      default: v1 = {{12{r[19]}}, r[19:0]};
    endcase
    if (kind < 20) begin
      // noise over the whole field range
      cmd = cmd_t'($urandom_range(0, 1));
      x1  = $urandom();
      x2  = $urandom();
    end else begin
      cmd  = (kind < 85) ? CMD_POSITION : CMD_ATTRIBUTE;
      base = longint'($urandom_range(0, 32'(b))) - b / 2;
      case ($urandom_range(0, 3))
        0:       delta = longint'($urandom_range(0, 32'(b)));
        // straddle the half-box threshold
        1:       delta = b / 2 + longint'($urandom_range(0, 2)) - 1;
        2:       delta = longint'($urandom_range(0, 4096));
        default: delta = b + longint'($urandom_range(0, 32'(b)));
      endcase
      if ($urandom_range(0, 1)) delta = -delta;
      x1 = 32'(base);
      x2 = 32'(base + delta);
    end
    send_request(cmd, x1, x2, v1, $urandom());
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: fraction zero gives x1, zero box wraps by nothing
    send_request(CMD_POSITION, 5 << 16, 7 << 16, 0, 0);
    send_request(CMD_POSITION, 3, 3, 0, 0);
    send_request(CMD_ATTRIBUTE, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN);
    wait_results_drained();

    // all registers at their top, quadratic, plus writes to unused indexes
    program_regs(16'hFFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(CMD_POSITION, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN);
    send_request(CMD_POSITION, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
    send_request(CMD_POSITION, 0, 0, VAL_MAX, 0);
    send_request(CMD_POSITION, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
    send_request(CMD_ATTRIBUTE, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX);
    send_request(CMD_ATTRIBUTE, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN);
    wait_results_drained();

    // half point, 16.0 box, linear: exactly half a box does not wrap
    program_regs(16'h8000, 31'(16 << 16), 1'b1, 1'b0, 32'h0, 32'h0, 1'b0);
    send_request(CMD_POSITION, 0, 8 << 16, 0, 0);
    send_request(CMD_POSITION, 0, (8 << 16) + 1, 0, 0);
    send_request(CMD_POSITION, 0, -(8 << 16) - 1, 0, 0);
    send_request(CMD_ATTRIBUTE, 0, 12 << 16, 0, 0);
    send_request(CMD_POSITION, VAL_MIN, VAL_MAX, 0, 0);
    wait_results_drained();

    // smallest fraction, wrap off, quadratic: saturation at both ends
    program_regs(16'h0001, 31'(16 << 16), 1'b0, 1'b1, 32'h0100_0000, 32'h1234_5678,
                 1'b0);
    send_request(CMD_POSITION, 0, 12 << 16, 1 << 16, 0);
    send_request(CMD_POSITION, VAL_MAX, VAL_MAX, VAL_MAX, 0);
    send_request(CMD_POSITION, VAL_MIN, VAL_MIN, VAL_MIN, 0);
    send_request(CMD_ATTRIBUTE, VAL_MAX, VAL_MIN, 0, 0);
    wait_results_drained();

    // random settings; one phase runs with no idling on either side
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_setting();
      no_idle <= (ph == 2);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_random_request();
        if (n == RAND_PER_PHASE / 2 && ph % 3 == 0) wait_results_drained();
      end
      wait_results_drained();
    end

    // stray results would show up here
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
